### sv/fas_pkg.sv
// Shared field widths, types, opcodes, mode codes and register indexes of the frame animation sequencer.
package fas_pkg;

	localparam int OPCODE_W   = 3;
	localparam int TIME_W     = 16;
	localparam int EPOS_W     = 6;
	localparam int FRAME_W    = 8;
	localparam int DWELL_IN_W = 16;
	localparam int ADV_W      = 8;
	localparam int ACC_W      = 32;
	localparam int MODE_W     = 2;
	localparam int GAIN_W     = 10;
	localparam int SLEN_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int GAIN_FRAC  = 8;

	typedef logic [OPCODE_W-1:0]   opcode_t;
	typedef logic [TIME_W-1:0]     dtime_t;
	typedef logic [EPOS_W-1:0]     epos_t;
	typedef logic [FRAME_W-1:0]    frame_t;
	typedef logic [DWELL_IN_W-1:0] dwell_in_t;
	typedef logic [ADV_W-1:0]      adv_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam opcode_t OP_TICK   = 3'd0;
	localparam opcode_t OP_RESUME = 3'd1;
	localparam opcode_t OP_PAUSE  = 3'd2;
	localparam opcode_t OP_RESET  = 3'd3;
	localparam opcode_t OP_APPLY  = 3'd4;
	localparam opcode_t OP_LOAD   = 3'd5;

	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BWD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PP   = 2'd3;

	localparam cfg_idx_t CFG_MODE = 2'd0;
	localparam cfg_idx_t CFG_GAIN = 2'd1;
	localparam cfg_idx_t CFG_LEN  = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;
	localparam adv_t              ADV_MAX    = 8'd255;

endpackage

### sv/frame_animation_sequencer.sv
// Frame animation sequencer top level: command sequencer, dwell walk and cycle skip.
// A command other than a tick passes through the execute, wait and output states, and the
// output state holds until the result register is free. A tick walks one frame advance per
// pass through the wait and walk states; once the walk repeats a full cycle, the rest is
// skipped by a remainder division, a multiply and a sum. One item is in flight at a time.
// Reset: configuration to defaults, position 0, paused; store contents undefined until loaded.
module frame_animation_sequencer #(
	parameter int SEQ_DEPTH  = 64,
	parameter int DWELL_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  fas_pkg::cfg_idx_t  cfg_index,
	input  fas_pkg::cfg_data_t cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  fas_pkg::opcode_t   opcode,
	input  fas_pkg::dtime_t    delta_time,
	input  fas_pkg::epos_t     entry_pos,
	input  fas_pkg::frame_t    entry_frame,
	input  fas_pkg::dwell_in_t entry_dwell,
	output logic               result_valid,
	input  logic               result_stall,
	output fas_pkg::epos_t     position,
	output fas_pkg::frame_t    frame_number,
	output fas_pkg::adv_t      advances,
	output logic               finished,
	output logic               is_paused
);

	import fas_pkg::*;

	// Position can reach SEQ_DEPTH itself, one step past the last entry.
	localparam int POS_W     = $clog2(SEQ_DEPTH + 1);
	localparam int IDX_W     = $clog2(SEQ_DEPTH);
	localparam int MEM_W     = FRAME_W + DWELL_BITS;
	// A cycle visits at most two states per position, which bounds its length and dwell sum.
	localparam int CL_W      = POS_W + 1;
	localparam int CS_W      = DWELL_BITS + POS_W + 1;
	localparam int STEP_LIM  = 2 * SEQ_DEPTH + 2;
	localparam int STEP_W    = $clog2(STEP_LIM + 1);
	localparam int SUB_W     = (CS_W + 1 > ACC_W) ? CS_W + 1 : ACC_W;
	localparam int TG_W      = TIME_W + GAIN_W;
	localparam int PROD_W    = ADV_W + CL_W;
	localparam int DIV_CNT_W = $clog2(ACC_W);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT,
		ST_WALK,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t                 state_q;

	// Configuration registers.
	logic [MODE_W-1:0]      anim_mode_q;
	logic [GAIN_W-1:0]      speed_gain_q;
	logic [SLEN_W-1:0]      seq_length_q;

	// The accepted item.
	opcode_t                op_q;
	dtime_t                 delta_q;
	epos_t                  epos_q;
	frame_t                 eframe_q;
	logic [DWELL_BITS-1:0]  edwell_q;

	// Animation state.
	logic [ACC_W-1:0]       time_accum_q;
	logic [POS_W-1:0]       cur_pos_q;
	logic                   going_back_q;
	logic                   paused_q;
	adv_t                   adv_q;
	logic                   fin_q;

	// Cycle detection and cycle skip.
	logic [STEP_W-1:0]      steps_q;
	logic                   anchored_q;
	logic                   reduced_q;
	logic [POS_W-1:0]       anc_pos_q;
	logic                   anc_dir_q;
	logic [CS_W-1:0]        cyc_sum_q;
	logic [CL_W-1:0]        cyc_len_q;
	logic [CS_W:0]          rem_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   big_q;

	// Result register.
	logic                   result_valid_q;
	epos_t                  position_q;
	frame_t                 frame_number_q;
	adv_t                   advances_q;
	logic                   finished_q;
	logic                   is_paused_q;

	logic [POS_W-1:0]       len_w;
	logic [POS_W-1:0]       len_m1;
	logic [POS_W-1:0]       nxt_pos;
	logic                   nxt_back;
	logic                   nxt_fin;
	logic                   adv_move;
	logic [TG_W-1:0]        gain_prod;
	logic [ACC_W:0]         acc_sum;
	logic [ACC_W-1:0]       acc_sat;
	logic [CS_W:0]          rem_sh;
	logic [SUB_W-1:0]       alu_a;
	logic [SUB_W-1:0]       alu_b;
	logic [SUB_W-1:0]       alu_diff;
	logic                   alu_ge;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [MEM_W-1:0]       mem_wdata;
	logic [IDX_W-1:0]       mem_raddr;
	logic [MEM_W-1:0]       mem_rdata;
	frame_t                 rd_frame;
	logic [DWELL_BITS-1:0]  rd_dwell;
	logic [31:0]            epos_ext;
	logic [31:0]            dwell_ext;
	logic [31:0]            pos_ext;
	logic [STEP_W-1:0]      steps_nxt;
	logic [CS_W-1:0]        cyc_sum_nxt;
	logic [PROD_W:0]        adv_total;
	logic                   out_free;
	adv_t                   adv_inc;
	logic                   cyc_hit;

	// Handshakes: one item at a time, configuration only between items.
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign out_free   = ~result_valid_q | ~result_stall;

	// Effective length is the configured length clipped to the store depth.
	always_comb begin
		if (32'(seq_length_q) > 32'(SEQ_DEPTH)) begin
			len_w = POS_W'(SEQ_DEPTH);
		end else begin
			len_w = POS_W'(seq_length_q);
		end
	end
	assign len_m1 = len_w - POS_W'(1);

	// One frame advance under the mode rules. Ping-pong turns at either end, loop wraps at
	// the last entry, forward and backward finish at their own end. A step back from
	// position zero stays at zero, which keeps a one-entry backward sequence looping.
	always_comb begin
		nxt_pos  = cur_pos_q;
		nxt_back = going_back_q;
		nxt_fin  = 1'b0;
		adv_move = 1'b1;
		if (cur_pos_q == len_m1) begin
			if (anim_mode_q == MODE_PP) begin
				nxt_back = 1'b1;
			end else if (anim_mode_q == MODE_LOOP) begin
				nxt_pos  = '0;
				adv_move = 1'b0;
			end else if (anim_mode_q == MODE_FWD) begin
				nxt_fin  = 1'b1;
				adv_move = 1'b0;
			end
		end else if (cur_pos_q == '0) begin
			if (anim_mode_q == MODE_PP) begin
				nxt_back = 1'b0;
			end else if (anim_mode_q == MODE_BWD) begin
				nxt_fin  = 1'b1;
				adv_move = 1'b0;
			end
		end
		if (adv_move) begin
			if (!nxt_back) begin
				nxt_pos = cur_pos_q + POS_W'(1);
			end else if (cur_pos_q != '0) begin
				nxt_pos = cur_pos_q - POS_W'(1);
			end
		end
	end

	// Tick scaling: Q2.8 gain, truncated, with a saturating add into the accumulator.
	assign gain_prod = TG_W'(delta_q) * TG_W'(speed_gain_q);
	assign acc_sum   = {1'b0, time_accum_q} + (ACC_W + 1)'(gain_prod[TG_W-1:GAIN_FRAC]);
	assign acc_sat   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	// The divider shifts the dividend out of the top of the accumulator and the quotient
	// into its bottom, so the accumulator holds the quotient after the last step.
	assign rem_sh = {rem_q[CS_W-1:0], time_accum_q[ACC_W-1]};

	always_comb begin
		if (state_q == ST_DIV) begin
			alu_a = SUB_W'(rem_sh);
			alu_b = SUB_W'(cyc_sum_q);
		end else begin
			alu_a = SUB_W'(time_accum_q);
			alu_b = SUB_W'(rd_dwell);
		end
	end

	fas_alu #(
		.W(SUB_W)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.diff(alu_diff),
		.ge  (alu_ge)
	);

	// Sequence store. The read port follows the current position every cycle.
	assign epos_ext  = 32'(epos_q);
	assign dwell_ext = 32'(entry_dwell);
	assign pos_ext   = 32'(cur_pos_q);
	assign mem_we    = (state_q == ST_EXEC) && (op_q == OP_LOAD) && (epos_ext < 32'(SEQ_DEPTH));
	assign mem_waddr = epos_ext[IDX_W-1:0];
	assign mem_wdata = {eframe_q, edwell_q};
	assign mem_raddr = cur_pos_q[IDX_W-1:0];
	assign rd_frame  = mem_rdata[MEM_W-1 -: FRAME_W];
	assign rd_dwell  = mem_rdata[DWELL_BITS-1:0];

	fas_seq_mem #(
		.DEPTH(SEQ_DEPTH),
		.AW   (IDX_W),
		.DW   (MEM_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign steps_nxt   = steps_q + STEP_W'(1);
	assign cyc_sum_nxt = cyc_sum_q + CS_W'(rd_dwell);
	assign adv_total   = (PROD_W + 1)'(adv_q) + (PROD_W + 1)'(prod_q);
	assign adv_inc     = (adv_q == ADV_MAX) ? ADV_MAX : adv_q + ADV_W'(1);

	// An advance that brings an anchored walk back to its anchor starts the cycle skip.
	assign cyc_hit = anchored_q && !reduced_q && !nxt_fin &&
		(nxt_pos == anc_pos_q) && (nxt_back == anc_dir_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			anim_mode_q    <= MODE_FWD;
			speed_gain_q   <= GAIN_RESET;
			seq_length_q   <= '0;
			op_q           <= OP_TICK;
			delta_q        <= '0;
			epos_q         <= '0;
			eframe_q       <= '0;
			edwell_q       <= '0;
			time_accum_q   <= '0;
			cur_pos_q      <= '0;
			going_back_q   <= 1'b0;
			paused_q       <= 1'b1;
			adv_q          <= '0;
			fin_q          <= 1'b0;
			steps_q        <= '0;
			anchored_q     <= 1'b0;
			reduced_q      <= 1'b0;
			anc_pos_q      <= '0;
			anc_dir_q      <= 1'b0;
			cyc_sum_q      <= '0;
			cyc_len_q      <= '0;
			rem_q          <= '0;
			div_cnt_q      <= '0;
			prod_q         <= '0;
			big_q          <= 1'b0;
			result_valid_q <= 1'b0;
			position_q     <= '0;
			frame_number_q <= '0;
			advances_q     <= '0;
			finished_q     <= 1'b0;
			is_paused_q    <= 1'b1;
		end else begin
			// The result register drains independently of the sequencer, unless a new
			// result beat replaces the departing one in the same cycle.
			if (result_valid_q && !result_stall && state_q != ST_OUT) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							CFG_MODE: anim_mode_q  <= cfg_data[MODE_W-1:0];
							CFG_GAIN: speed_gain_q <= cfg_data[GAIN_W-1:0];
							CFG_LEN:  seq_length_q <= cfg_data[SLEN_W-1:0];
							default: ;
						endcase
					end
					if (item_valid) begin
						op_q       <= opcode;
						delta_q    <= delta_time;
						epos_q     <= entry_pos;
						eframe_q   <= entry_frame;
						edwell_q   <= dwell_ext[DWELL_BITS-1:0];
						adv_q      <= '0;
						fin_q      <= 1'b0;
						steps_q    <= '0;
						anchored_q <= 1'b0;
						reduced_q  <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					unique case (op_q)
						OP_TICK: begin
							if (!paused_q) begin
								time_accum_q <= acc_sat;
							end
						end
						OP_RESUME: paused_q <= 1'b0;
						OP_PAUSE:  paused_q <= 1'b1;
						OP_RESET: begin
							cur_pos_q    <= '0;
							time_accum_q <= '0;
							paused_q     <= 1'b1;
							fin_q        <= 1'b1;
						end
						OP_APPLY: begin
							// An empty sequence ignores it; ping-pong keeps its place.
							if (len_w != '0) begin
								if (anim_mode_q == MODE_FWD || anim_mode_q == MODE_LOOP) begin
									going_back_q <= 1'b0;
									cur_pos_q    <= '0;
								end else if (anim_mode_q == MODE_BWD) begin
									going_back_q <= 1'b1;
									cur_pos_q    <= len_m1;
								end
							end
						end
						default: ;
					endcase
					state_q <= ST_WAIT;
				end

				ST_WAIT: begin
					// The wait lets the store's registered read port follow the position.
					state_q <= (op_q == OP_TICK) ? ST_WALK : ST_OUT;
				end

				ST_WALK: begin
					if (time_accum_q == '0 || paused_q) begin
						state_q <= ST_OUT;
					end else if (len_w == '0 || cur_pos_q >= len_w) begin
						// Empty sequence, or the position ran off the end.
						time_accum_q <= '0;
						paused_q     <= 1'b1;
						fin_q        <= 1'b1;
						state_q      <= ST_OUT;
					end else if (rd_dwell == '0 || !alu_ge) begin
						// A zero dwell stalls; otherwise the time does not yet cover it.
						state_q <= ST_OUT;
					end else begin
						// Finishing drops whatever time is left.
						time_accum_q <= nxt_fin ? '0 : alu_diff[ACC_W-1:0];
						cur_pos_q    <= nxt_pos;
						going_back_q <= nxt_back;
						adv_q        <= adv_inc;
						state_q      <= cyc_hit ? ST_DIV : ST_WAIT;
						if (nxt_fin) begin
							paused_q <= 1'b1;
							fin_q    <= 1'b1;
						end else if (!reduced_q) begin
							if (anchored_q) begin
								cyc_sum_q <= cyc_sum_nxt;
								cyc_len_q <= cyc_len_q + CL_W'(1);
								if (cyc_hit) begin
									// Back at the anchor: skip all whole cycles left.
									rem_q     <= '0;
									div_cnt_q <= '0;
								end
							end else begin
								steps_q <= steps_nxt;
								if (32'(steps_nxt) >= STEP_LIM) begin
									anchored_q <= 1'b1;
									anc_pos_q  <= nxt_pos;
									anc_dir_q  <= nxt_back;
									cyc_sum_q  <= '0;
									cyc_len_q  <= '0;
								end
							end
						end
					end
				end

				ST_DIV: begin
					// Restoring division, one quotient bit a cycle.
					if (alu_ge) begin
						rem_q <= alu_diff[CS_W:0];
					end else begin
						rem_q <= rem_sh;
					end
					time_accum_q <= {time_accum_q[ACC_W-2:0], alu_ge};
					div_cnt_q    <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					prod_q       <= PROD_W'(time_accum_q[ADV_W-1:0]) * PROD_W'(cyc_len_q);
					big_q        <= |time_accum_q[ACC_W-1:ADV_W];
					time_accum_q <= ACC_W'(rem_q);
					state_q      <= ST_SUM;
				end

				ST_SUM: begin
					if (big_q || adv_total > (PROD_W + 1)'(ADV_MAX)) begin
						adv_q <= ADV_MAX;
					end else begin
						adv_q <= adv_total[ADV_W-1:0];
					end
					reduced_q <= 1'b1;
					state_q   <= ST_WAIT;
				end

				ST_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						position_q     <= pos_ext[EPOS_W-1:0];
						frame_number_q <= (pos_ext < 32'(SEQ_DEPTH)) ? rd_frame : '0;
						advances_q     <= adv_q;
						finished_q     <= fin_q;
						is_paused_q    <= paused_q;
						state_q        <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign position     = position_q;
	assign frame_number = frame_number_q;
	assign advances     = advances_q;
	assign finished     = finished_q;
	assign is_paused    = is_paused_q;

	// The position never runs more than one step past the last store entry.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_pos_q <= POS_W'(SEQ_DEPTH))
		else $error("position beyond store depth");

	// Finishing always empties the accumulator and pauses, for the rest of the item.
	a_fin_state: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (time_accum_q == '0 && paused_q))
		else $error("finished without cleared accumulator and pause");

	// The cycle skip only runs once per tick, on a measured non-empty cycle.
	a_div_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (anchored_q && !reduced_q && cyc_len_q != '0))
		else $error("cycle skip outside an anchored walk");

	// A free result register takes the result and the sequencer returns to idle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (result_valid_q && state_q == ST_IDLE))
		else $error("result beat not presented");

endmodule

### sv/fas_seq_mem.sv
// Sequence entry store: one write port and one registered read port.
module fas_seq_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/fas_alu.sv
// Shared subtract and compare unit used by the dwell walk and the remainder divider.
module fas_alu #(
	parameter int W = 32
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);

	logic [W:0] wide;

	// The borrow out of the widened subtraction tells whether a covers b.
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[W-1:0];
	assign ge   = ~wide[W];

endmodule

### sim/frame_animation_sequencer_tb.sv
// Self-checking testbench for the frame animation sequencer: stimulus, prediction and checking.
module frame_animation_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fas_pkg::*;

	localparam int STORE_DEPTH    = 64;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 60;
	// The limit covers a tick that walks into its cycle, divides and walks the remainder,
	// plus a long result hold-off, and leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 7000;

	localparam opcode_t  OP_SPARE6  = 3'd6;
	localparam opcode_t  OP_SPARE7  = 3'd7;
	localparam cfg_idx_t CFG_UNUSED = 2'd3;

	// One command beat as it goes into the block.
	typedef struct packed {
		opcode_t   op;
		dtime_t    dt;
		epos_t     pos;
		frame_t    frm;
		dwell_in_t dwl;
	} anim_cmd_t;

	// One result beat as it comes out of the block.
	typedef struct packed {
		epos_t  pos;
		frame_t frm;
		adv_t   adv;
		logic   fin;
		logic   paused;
	} anim_view_t;

	// Per-phase settings: the extremes of every register appear at least once.
	logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_FWD, MODE_BWD, MODE_LOOP, MODE_PP,
		MODE_BWD, MODE_FWD, MODE_PP, MODE_LOOP, MODE_BWD, MODE_PP, MODE_FWD, MODE_LOOP};
	logic [GAIN_W-1:0] phase_gain [PHASES] = '{10'd256, 10'd1023, 10'd0, 10'd300,
		10'd256, 10'd1023, 10'd17, 10'd512, 10'd1023, 10'd64, 10'd256, 10'd1};
	logic [SLEN_W-1:0] phase_len [PHASES] = '{7'd8, 7'd1, 7'd64, 7'd127,
		7'd64, 7'd0, 7'd2, 7'd16, 7'd5, 7'd64, 7'd3, 7'd40};

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      cfg_valid    = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index    = CFG_MODE;
	cfg_data_t cfg_data     = '0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	opcode_t   opcode       = OP_TICK;
	dtime_t    delta_time   = '0;
	epos_t     entry_pos    = '0;
	frame_t    entry_frame  = '0;
	dwell_in_t entry_dwell  = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	epos_t     position;
	frame_t    frame_number;
	adv_t      advances;
	logic      finished;
	logic      is_paused;

	// Predicted state of the sequencer, including its own copy of the configuration.
	logic [MODE_W-1:0] ms_mode   = MODE_FWD;
	logic [GAIN_W-1:0] ms_gain   = GAIN_RESET;
	logic [SLEN_W-1:0] ms_len    = '0;
	logic [ACC_W-1:0]  ms_accum  = '0;
	logic [6:0]        ms_pos    = '0;
	logic              ms_back   = 1'b0;
	logic              ms_halted = 1'b1;
	frame_t            ms_frame [STORE_DEPTH];
	dwell_in_t         ms_dwell [STORE_DEPTH];

	// Commands waiting to be driven and results still owed by the block.
	anim_cmd_t   cmd_q[$];
	anim_view_t  beat_q[$];
	anim_cmd_t   cur_cmd;
	int unsigned sent_n      = 0;
	int unsigned done_n      = 0;
	int unsigned fail_cnt    = 0;
	int unsigned idle_cnt    = 0;
	int unsigned idle_pct    = 0;
	int unsigned stall_pct   = 0;
	int unsigned hold_left   = 0;
	logic        hold_req    = 1'b0;
	logic        item_taken  = 1'b0;

	frame_animation_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.delta_time   (delta_time),
		.entry_pos    (entry_pos),
		.entry_frame  (entry_frame),
		.entry_dwell  (entry_dwell),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.position     (position),
		.frame_number (frame_number),
		.advances     (advances),
		.finished     (finished),
		.is_paused    (is_paused)
	);

	always #2 clk = ~clk;

	// Number of usable entries: the length register, clipped to the store depth.
	function automatic int seq_span();
		return (ms_len > STORE_DEPTH) ? STORE_DEPTH : int'(ms_len);
	endfunction

	// End of the animation: the accumulated time is dropped and playback pauses.
	function automatic void halt_anim(inout logic fin);
		ms_accum  = '0;
		ms_halted = 1'b1;
		fin       = 1'b1;
	endfunction

	// Moves one entry on according to the mode, turning or finishing at the ends.
	function automatic void step_entry(input int len, inout logic fin);
		if (ms_pos == len - 1) begin
			if (ms_mode == MODE_PP) begin
				ms_back = 1'b1;
			end else if (ms_mode == MODE_LOOP) begin
				ms_pos = '0;
				return;
			end else if (ms_mode == MODE_FWD) begin
				halt_anim(fin);
				return;
			end
		end else if (ms_pos == 0) begin
			if (ms_mode == MODE_PP) begin
				ms_back = 1'b0;
			end else if (ms_mode == MODE_BWD) begin
				halt_anim(fin);
				return;
			end
		end
		if (!ms_back)
			ms_pos = ms_pos + 7'd1;
		else if (ms_pos != 0)
			ms_pos = ms_pos - 7'd1;
	endfunction

	// Spends accumulated time on dwells. Once the walk has settled into its repeating
	// cycle, whole cycles are taken off in one division so huge budgets stay cheap.
	function automatic adv_t walk_frames(inout logic fin);
		int          len;
		int unsigned cnt;
		int unsigned steps;
		int unsigned cyc_n;
		logic [63:0] cyc_sum;
		logic [63:0] laps;
		logic [63:0] total;
		logic [6:0]  anc_pos;
		logic        anc_back;
		logic        anchored;
		logic        skipped;
		logic        walking;
		dwell_in_t   d;
		len      = seq_span();
		cnt      = 0;
		steps    = 0;
		cyc_n    = 0;
		cyc_sum  = '0;
		anc_pos  = '0;
		anc_back = 1'b0;
		anchored = 1'b0;
		skipped  = 1'b0;
		walking  = 1'b1;
		while (walking && ms_accum != 0 && !ms_halted) begin
			if (len == 0 || ms_pos >= len) begin
				halt_anim(fin);
				walking = 1'b0;
			end else begin
				d = ms_dwell[ms_pos[5:0]];
				if (d == 0 || ms_accum < d) begin
					walking = 1'b0;
				end else begin
					ms_accum = ms_accum - d;
					step_entry(len, fin);
					if (cnt < 255)
						cnt++;
					if (!skipped && !ms_halted) begin
						if (anchored) begin
							cyc_sum = cyc_sum + d;
							cyc_n++;
							if (ms_pos == anc_pos && ms_back == anc_back) begin
								laps     = 64'(ms_accum) / cyc_sum;
								total    = 64'(cnt) + laps * 64'(cyc_n);
								cnt      = (total > 255) ? 255 : int'(total);
								ms_accum = 32'(64'(ms_accum) % cyc_sum);
								skipped  = 1'b1;
							end
						end else begin
							steps++;
							if (steps >= 2 * STORE_DEPTH + 2) begin
								anchored = 1'b1;
								anc_pos  = ms_pos;
								anc_back = ms_back;
							end
						end
					end
				end
			end
		end
		return adv_t'(cnt);
	endfunction

	// Applies one accepted command to the predicted state and returns the beat it owes.
	function automatic anim_view_t predict_beat(anim_cmd_t c);
		anim_view_t  v;
		logic        fin;
		logic [63:0] scaled;
		logic [63:0] sum;
		int          len;
		fin   = 1'b0;
		v.adv = '0;
		case (c.op)
			OP_TICK: begin
				if (!ms_halted) begin
					scaled   = (64'(c.dt) * 64'(ms_gain)) >> GAIN_FRAC;
					sum      = 64'(ms_accum) + scaled;
					ms_accum = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
				end
				v.adv = walk_frames(fin);
			end
			OP_RESUME: ms_halted = 1'b0;
			OP_PAUSE:  ms_halted = 1'b1;
			OP_RESET: begin
				ms_pos    = '0;
				ms_accum  = '0;
				ms_halted = 1'b1;
				fin       = 1'b1;
			end
			OP_APPLY: begin
				len = seq_span();
				if (len != 0) begin
					if (ms_mode == MODE_FWD || ms_mode == MODE_LOOP) begin
						ms_back = 1'b0;
						ms_pos  = '0;
					end else if (ms_mode == MODE_BWD) begin
						ms_back = 1'b1;
						ms_pos  = 7'(len - 1);
					end
				end
			end
			OP_LOAD: begin
				ms_frame[c.pos] = c.frm;
				ms_dwell[c.pos] = c.dwl;
			end
			default: ;
		endcase
		v.pos    = ms_pos[5:0];
		v.frm    = (ms_pos < STORE_DEPTH) ? ms_frame[ms_pos[5:0]] : '0;
		v.fin    = fin;
		v.paused = ms_halted;
		return v;
	endfunction

	// Dwells lean small so that ticks walk many entries; zero is rare as it stalls playback.
	function automatic dwell_in_t rand_dwell();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		else if (r < 50)
			return dwell_in_t'($urandom_range(15, 1));
		else if (r < 80)
			return dwell_in_t'($urandom_range(4095, 16));
		return dwell_in_t'($urandom);
	endfunction

	// Mostly ticks and resumes, so that playback keeps running; the rest is control noise.
	function automatic anim_cmd_t rand_cmd();
		anim_cmd_t   c;
		int unsigned r;
		c.pos = epos_t'($urandom);
		c.frm = frame_t'($urandom);
		c.dwl = rand_dwell();
		r     = $urandom_range(9);
		if (r == 0)
			c.dt = '0;
		else if (r < 4)
			c.dt = dtime_t'($urandom_range(255));
		else if (r < 8)
			c.dt = dtime_t'($urandom);
		else if (r == 8)
			c.dt = '1;
		else
			c.dt = dtime_t'($urandom_range(4095));
		r = $urandom_range(99);
		if (r < 52)
			c.op = OP_TICK;
		else if (r < 66)
			c.op = OP_RESUME;
		else if (r < 71)
			c.op = OP_PAUSE;
		else if (r < 75)
			c.op = OP_RESET;
		else if (r < 82)
			c.op = OP_APPLY;
		else if (r < 98)
			c.op = OP_LOAD;
		else if (r < 99)
			c.op = OP_SPARE6;
		else
			c.op = OP_SPARE7;
		return c;
	endfunction

	function automatic anim_cmd_t pick(opcode_t op, dtime_t dt);
		anim_cmd_t c;
		c    = rand_cmd();
		c.op = op;
		c.dt = dt;
		return c;
	endfunction

	function automatic anim_cmd_t load_cmd(epos_t pos, frame_t frm, dwell_in_t dwl);
		anim_cmd_t c;
		c     = rand_cmd();
		c.op  = OP_LOAD;
		c.pos = pos;
		c.frm = frm;
		c.dwl = dwl;
		return c;
	endfunction

	task automatic queue_cmd(anim_cmd_t c);
		cmd_q = {cmd_q, c};
		sent_n++;
	endtask

	// Returns at a falling edge once every queued command has produced its result beat.
	task automatic drain();
		do
			@(negedge clk);
		while (done_n != sent_n);
	endtask

	// Writes all three registers, and the unused index as well when asked. Unused upper
	// bits of the data word carry random values, which the block must ignore.
	task automatic set_config(input logic [MODE_W-1:0] m, input logic [GAIN_W-1:0] g,
			input logic [SLEN_W-1:0] l, input logic spare);
		cfg_idx_t  idx;
		cfg_data_t d;
		for (int i = 0; i < 4; i++) begin
			if (i < 3 || spare) begin
				case (i)
					0: begin
						idx = CFG_MODE;
						d   = {8'($urandom), m};
					end
					1: begin
						idx = CFG_GAIN;
						d   = g;
					end
					2: begin
						idx = CFG_LEN;
						d   = {3'($urandom), l};
					end
					default: begin
						idx = CFG_UNUSED;
						d   = cfg_data_t'($urandom);
					end
				endcase
				@(negedge clk);
				cfg_valid <= 1'b1;
				cfg_index <= idx;
				cfg_data  <= d;
				do
					@(posedge clk);
				while (!cfg_ready);
				case (idx)
					CFG_MODE: ms_mode = d[MODE_W-1:0];
					CFG_GAIN: ms_gain = d;
					CFG_LEN:  ms_len  = d[SLEN_W-1:0];
					default: ;
				endcase
			end
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: a new command beat is offered only once the previous one has been taken,
	// and the payload is held steady while the block stalls it.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cur_cmd = cmd_q.pop_front();
				item_valid  <= 1'b1;
				opcode      <= cur_cmd.op;
				delta_time  <= cur_cmd.dt;
				entry_pos   <= cur_cmd.pos;
				entry_frame <= cur_cmd.frm;
				entry_dwell <= cur_cmd.dwl;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that is counted down here so that
	// the single in-flight item backs up into the command channel.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: predicts on every accepted command beat, checks every accepted result
	// beat against the oldest prediction, and runs the watchdog.
	always @(posedge clk) begin
		anim_view_t want;
		anim_view_t got;
		logic       res_taken;
		item_taken = arst_n && item_valid && !item_stall;
		res_taken  = arst_n && result_valid && !result_stall;
		if (item_taken)
			beat_q = {beat_q, predict_beat(cur_cmd)};
		if (res_taken) begin
			got = '{position, frame_number, advances, finished, is_paused};
			if (beat_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: result beat with none expected: %s %0d frame %0d adv %0d %s %b %s %b",
					$time, "pos", got.pos, got.frm, got.adv, "fin", got.fin,
					"paused", got.paused);
			end else begin
				want = beat_q.pop_front();
				done_n++;
				if (got !== want) begin
					fail_cnt++;
					$display("%0t: mismatch exp pos %0d frame %0d adv %0d fin %b paused %b",
						$time, want.pos, want.frm, want.adv, want.fin, want.paused);
					$display("%0t:          got pos %0d frame %0d adv %0d fin %b paused %b",
						$time, got.pos, got.frm, got.adv, got.fin, got.paused);
				end
			end
		end
		if (item_taken || res_taken || (cfg_valid && cfg_ready)) begin
			idle_cnt = 0;
		end else begin
			idle_cnt++;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("frame_animation_sequencer_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Entries 0 to 3 and entry 63 are loaded here, but the length stays at 3,
		// so no position beyond them is ever shown. Entry 1 carries the largest dwell and
		// entry 2 a zero dwell, which must stall the walk however much time is banked.
		set_config(MODE_FWD, GAIN_RESET, 7'd3, 1'b0);
		@(posedge clk);
		queue_cmd(load_cmd(6'd0, 8'h00, 16'h0001));
		queue_cmd(load_cmd(6'd1, 8'hFF, 16'hFFFF));
		queue_cmd(load_cmd(6'd2, 8'hA5, 16'h0000));
		queue_cmd(load_cmd(6'd3, 8'h5A, 16'h00FF));
		queue_cmd(load_cmd(6'd63, 8'hFF, 16'hFFFF));
		queue_cmd(pick(OP_TICK, 16'hFFFF));
		queue_cmd(pick(OP_RESUME, dtime_t'($urandom)));
		queue_cmd(pick(OP_TICK, 16'h0000));
		queue_cmd(pick(OP_TICK, 16'h0001));
		queue_cmd(pick(OP_TICK, 16'hFFFF));
		queue_cmd(pick(OP_TICK, 16'hFFFF));
		queue_cmd(pick(OP_SPARE6, dtime_t'($urandom)));
		queue_cmd(pick(OP_SPARE7, dtime_t'($urandom)));
		queue_cmd(pick(OP_PAUSE, dtime_t'($urandom)));
		queue_cmd(pick(OP_TICK, 16'hFFFF));
		queue_cmd(pick(OP_APPLY, dtime_t'($urandom)));
		queue_cmd(pick(OP_RESUME, dtime_t'($urandom)));
		queue_cmd(pick(OP_TICK, 16'hFFFF));
		queue_cmd(pick(OP_RESET, dtime_t'($urandom)));
		queue_cmd(pick(OP_TICK, 16'h0001));

		// Random part. Each phase changes the settings while the block is idle, starts
		// playback from the mode's start position (ping-pong keeps its place), and then runs
		// mixed traffic. Halfway through every phase the sender waits until all results are back.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_config(phase_mode[p], (p == PHASES - 1) ? GAIN_W'($urandom) : phase_gain[p],
				(p == PHASES - 1) ? SLEN_W'($urandom_range(64, 1)) : phase_len[p], p == 7);
			@(posedge clk);
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 62;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 62;
				end
				default: begin
					idle_pct  = 30;
					stall_pct = 30;
				end
			endcase
			// The whole store is filled before any length reaches past the entries that
			// the directed part wrote.
			if (p == 0) begin
				for (int i = 0; i < STORE_DEPTH; i++)
					queue_cmd(load_cmd(epos_t'(i), frame_t'($urandom), rand_dwell()));
			end
			queue_cmd(pick(OP_APPLY, dtime_t'($urandom)));
			queue_cmd(pick(OP_RESUME, dtime_t'($urandom)));
			for (int n = 0; n < PHASE_ITEMS / 2; n++)
				queue_cmd(rand_cmd());
			if (p == 4)
				hold_req = 1'b1;
			drain();
			@(posedge clk);
			for (int n = 0; n < PHASE_ITEMS / 2; n++)
				queue_cmd(rand_cmd());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("frame_animation_sequencer_tb: done, clean");
		else
			$display("frame_animation_sequencer_tb: done, errors");
		$finish;
	end

endmodule

### files.f
sv/fas_pkg.sv
sv/fas_seq_mem.sv
sv/fas_alu.sv
sv/frame_animation_sequencer.sv
sim/frame_animation_sequencer_tb.sv
